FILE: sv/positional_list_engine_top_macros.svh
// assertion helpers for the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// property that holds every cycle outside reset
`define PLE_ASSERT(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// next-cycle implication outside reset
`define PLE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int LIMIT    = (CAPACITY < 16) ? CAPACITY : 16;
    localparam int IDX_W    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam int CNT_W    = 5;
    localparam int VAL_W    = 32;

    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_BACK  = 3'd1;
    localparam logic [2:0] REQ_INS_POS   = 3'd2;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
    localparam logic [2:0] REQ_DUMP      = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam logic [1:0] OP_HOLD      = 2'd0;
    localparam logic [1:0] OP_INSERT    = 2'd1;
    localparam logic [1:0] OP_DEL_FRONT = 2'd2;
    localparam logic [1:0] OP_ROTATE    = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] last_idx;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

FILE: sv/ple_cell.sv
`timescale 1ns / 1ps

module ple_cell (
    input  logic                       aclk,
    input  ple_pkg::cell_ctrl_t        ctrl,
    input  logic [ple_pkg::IDX_W-1:0]  cell_idx,
    input  logic [ple_pkg::VAL_W-1:0]  left_value,
    input  logic [ple_pkg::VAL_W-1:0]  right_value,
    input  logic [ple_pkg::VAL_W-1:0]  head_value,
    output logic [ple_pkg::VAL_W-1:0]  value
);

    logic [ple_pkg::VAL_W-1:0] value_reg;
    logic [ple_pkg::VAL_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        unique case (ctrl.op)
            ple_pkg::OP_INSERT: begin
                if (cell_idx == ctrl.idx) begin
                    value_next = ctrl.value;
                end else if (cell_idx > ctrl.idx) begin
                    value_next = left_value;
                end
            end
            ple_pkg::OP_DEL_FRONT: begin
                value_next = right_value;
            end
            ple_pkg::OP_ROTATE: begin
                if (cell_idx < ctrl.last_idx) begin
                    value_next = right_value;
                end else if (cell_idx == ctrl.last_idx) begin
                    value_next = head_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: sv/positional_list_engine_top.sv
`timescale 1ns / 1ps
// positional list engine: ordered list of signed 32-bit entries held in a chain of cells
// input channel s_*: one request per handshake (req_type, entry_value, insert_position)
// result channel m_*: status, entry_count, item_value, item_valid, last_item
// inserts and front deletes move every cell at once, a back delete only lowers the count;
// the single result of each such request appears in the output register on the next cycle
// s_ready is high whenever no dump is running and the output register is free
// or being taken, so these requests sustain one per cycle
// a dump of n entries returns n results, one per step of the cell
// chain rotating toward the front; s_ready stays low until the last one is sent,
// after which the list is back in its original order
// an empty dump, and every non-dump request, returns exactly one result
// when the receiver stalls, the output register holds its result, the dump
// pauses in place and s_ready goes low
// reset (aresetn low, synchronous) empties the list and drops any pending result;
// cell contents are not cleared and need no clearing pass
module positional_list_engine_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic signed [31:0] s_entry_value,
    input  logic [4:0]         s_insert_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [4:0]         m_entry_count,
    output logic signed [31:0] m_item_value,
    output logic               m_item_valid,
    output logic               m_last_item
);

    `include "positional_list_engine_top_macros.svh"

    localparam int LIMIT = ple_pkg::LIMIT;
    localparam int IDX_W = ple_pkg::IDX_W;
    localparam int CNT_W = ple_pkg::CNT_W;
    localparam int VAL_W = ple_pkg::VAL_W;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] dump_idx_reg, dump_idx_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0] item_reg, item_next;
    logic             item_valid_reg, item_valid_next;
    logic             last_reg, last_next;
    logic             load_out;

    ple_pkg::cell_ctrl_t ctrl;
    logic [VAL_W-1:0]    cell_value [LIMIT];

    logic out_free;
    logic accept;
    logic full;
    logic badpos;
    logic dump_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !busy_reg && out_free;
    assign accept    = s_valid && s_ready;
    assign full      = (cnt_reg >= CNT_W'(LIMIT));
    assign badpos    = (s_insert_position == 5'd0) ||
                       ({1'b0, s_insert_position} > ({1'b0, cnt_reg} + 6'd1));
    assign dump_last = (dump_idx_reg == (cnt_reg - CNT_W'(1)));

    for (genvar g = 0; g < LIMIT; g++) begin : g_cell
        logic [VAL_W-1:0] left_w;
        logic [VAL_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_value[g-1];
        end
        if (g == LIMIT - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_value[g+1];
        end
        ple_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_idx    (IDX_W'(g)),
            .left_value  (left_w),
            .right_value (right_w),
            .head_value  (cell_value[0]),
            .value       (cell_value[g])
        );
    end

    always_comb begin
        ctrl.op         = ple_pkg::OP_HOLD;
        ctrl.idx        = '0;
        ctrl.last_idx   = IDX_W'(cnt_reg - CNT_W'(1));
        ctrl.value      = s_entry_value;
        cnt_next        = cnt_reg;
        busy_next       = busy_reg;
        dump_idx_next   = dump_idx_reg;
        load_out        = 1'b0;
        status_next     = ple_pkg::ST_OK;
        count_next      = cnt_reg;
        item_next       = '0;
        item_valid_next = 1'b0;
        last_next       = 1'b1;

        if (busy_reg) begin
            if (out_free) begin
                load_out        = 1'b1;
                item_next       = cell_value[0];
                item_valid_next = 1'b1;
                last_next       = dump_last;
                ctrl.op         = ple_pkg::OP_ROTATE;
                busy_next       = !dump_last;
                dump_idx_next   = dump_idx_reg + CNT_W'(1);
            end
        end else if (accept) begin
            load_out = 1'b1;
            unique case (s_req_type)
                ple_pkg::REQ_INS_FRONT: begin
                    if (full) begin
                        status_next = ple_pkg::ST_FULL;
                    end else begin
                        ctrl.op  = ple_pkg::OP_INSERT;
                        ctrl.idx = '0;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ple_pkg::REQ_INS_BACK: begin
                    if (full) begin
                        status_next = ple_pkg::ST_FULL;
                    end else begin
                        ctrl.op  = ple_pkg::OP_INSERT;
                        ctrl.idx = IDX_W'(cnt_reg);
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ple_pkg::REQ_INS_POS: begin
                    if (badpos) begin
                        status_next = ple_pkg::ST_BADPOS;
                    end else if (full) begin
                        status_next = ple_pkg::ST_FULL;
                    end else begin
                        ctrl.op  = ple_pkg::OP_INSERT;
                        ctrl.idx = IDX_W'(s_insert_position - 5'd1);
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ple_pkg::REQ_DEL_FRONT: begin
                    if (cnt_reg == '0) begin
                        status_next = ple_pkg::ST_EMPTY;
                    end else begin
                        ctrl.op  = ple_pkg::OP_DEL_FRONT;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                ple_pkg::REQ_DEL_BACK: begin
                    if (cnt_reg == '0) begin
                        status_next = ple_pkg::ST_EMPTY;
                    end else begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                ple_pkg::REQ_DUMP: begin
                    if (cnt_reg == '0) begin
                        status_next = ple_pkg::ST_EMPTY;
                    end else begin
                        item_next       = cell_value[0];
                        item_valid_next = 1'b1;
                        last_next       = (cnt_reg == CNT_W'(1));
                        ctrl.op         = ple_pkg::OP_ROTATE;
                        busy_next       = (cnt_reg != CNT_W'(1));
                        dump_idx_next   = CNT_W'(1);
                    end
                end
                default: begin
                    status_next = ple_pkg::ST_OK;
                end
            endcase
            count_next = cnt_next;
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            busy_reg     <= busy_next;
            dump_idx_reg <= dump_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            status_reg     <= status_next;
            count_reg      <= count_next;
            item_reg       <= item_next;
            item_valid_reg <= item_valid_next;
            last_reg       <= last_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_count = count_reg;
    assign m_item_value  = item_reg;
    assign m_item_valid  = item_valid_reg;
    assign m_last_item   = last_reg;

    `PLE_ASSERT(a_count_bound, cnt_reg <= CNT_W'(LIMIT), "entry count above capacity")
    `PLE_ASSERT(a_ready_not_dumping, !(s_ready && busy_reg), "request taken during dump")
    `PLE_ASSERT(a_dump_nonempty, !busy_reg || (cnt_reg != '0), "dump running on empty list")
    `PLE_ASSERT_NEXT(a_dump_count_stable, busy_reg, $stable(cnt_reg), "count moved during dump")
    `PLE_ASSERT_NEXT(a_empty_dump, accept && (s_req_type == ple_pkg::REQ_DUMP) && (cnt_reg == '0),
        m_valid && (m_status == ple_pkg::ST_EMPTY) && m_last_item && !m_item_valid,
        "empty dump result wrong")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // spare request codes, treated as no-ops by the block
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int          RANDOM_REQUESTS = 340;
    localparam int          REPORT_MAX = 10;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  count;
        logic [31:0] value;
        logic        valid;
        logic        last;
    } list_result_t;

    class list_mirror;
        logic [31:0]  cells [ple_pkg::LIMIT];
        int unsigned  held;
        list_result_t due_results [$];
        int unsigned  failures;
        int unsigned  requests;
        int unsigned  results_seen;
        int unsigned  dumps;
        int unsigned  hit_full;
        int unsigned  hit_badpos;
        int unsigned  hit_empty;

        function new();
            held = 0;
            failures = 0;
            requests = 0;
            results_seen = 0;
            dumps = 0;
            hit_full = 0;
            hit_badpos = 0;
            hit_empty = 0;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void push_result(logic [1:0] st, logic [31:0] v, logic vld, logic lst);
            list_result_t r;
            r.status = st;
            r.count  = held[4:0];
            r.value  = v;
            r.valid  = vld;
            r.last   = lst;
            due_results.push_back(r);
        endfunction

        function logic [1:0] insert_at(int unsigned slot, logic [31:0] v);
            int unsigned k;
            if (held >= ple_pkg::LIMIT) return ple_pkg::ST_FULL;
            for (k = held; k > slot; k--) cells[k] = cells[k-1];
            cells[slot] = v;
            held++;
            return ple_pkg::ST_OK;
        endfunction

        function void note_request(logic [2:0] req, logic [31:0] v, logic [4:0] pos);
            logic [1:0]  st;
            int unsigned k;
            st = ple_pkg::ST_OK;
            requests++;
            case (req)
                ple_pkg::REQ_INS_FRONT: st = insert_at(0, v);
                ple_pkg::REQ_INS_BACK:  st = insert_at(held, v);
                ple_pkg::REQ_INS_POS: begin
                    if (pos < 1 || pos > held + 1) st = ple_pkg::ST_BADPOS;
                    else st = insert_at(pos - 1, v);
                end
                ple_pkg::REQ_DEL_FRONT: begin
                    if (held == 0) begin
                        st = ple_pkg::ST_EMPTY;
                    end else begin
                        for (k = 0; k + 1 < held; k++) cells[k] = cells[k+1];
                        held--;
                    end
                end
                ple_pkg::REQ_DEL_BACK: begin
                    if (held == 0) st = ple_pkg::ST_EMPTY;
                    else held--;
                end
                ple_pkg::REQ_DUMP: begin
                    dumps++;
                    if (held == 0) begin
                        hit_empty++;
                        push_result(ple_pkg::ST_EMPTY, 32'd0, 1'b0, 1'b1);
                    end else begin
                        for (k = 0; k < held; k++)
                            push_result(ple_pkg::ST_OK, cells[k], 1'b1, k + 1 == held);
                    end
                    return;
                end
                default: ;
            endcase
            if (st == ple_pkg::ST_FULL) hit_full++;
            if (st == ple_pkg::ST_BADPOS) hit_badpos++;
            if (st == ple_pkg::ST_EMPTY) hit_empty++;
            push_result(st, 32'd0, 1'b0, 1'b1);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            string        bad;
            results_seen++;
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: st=%0d cnt=%0d val=%h vld=%b last=%b",
                             got.status, got.count, got.value, got.valid, got.last);
                return;
            end
            want = due_results.pop_front();
            bad = "";
            if (got.status !== want.status) bad = {bad, " status"};
            if (got.count !== want.count) bad = {bad, " count"};
            if (got.value !== want.value) bad = {bad, " value"};
            if (got.valid !== want.valid) bad = {bad, " valid"};
            if (got.last !== want.last) bad = {bad, " last"};
            if (bad != "") begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $display("mismatch on%s: want st=%0d cnt=%0d val=%h vld=%b last=%b",
                             bad, want.status, want.count, want.value, want.valid,
                             want.last);
                    $display("    got st=%0d cnt=%0d val=%h vld=%b last=%b",
                             got.status, got.count, got.value, got.valid, got.last);
                end
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_req_type;
    logic signed [31:0] s_entry_value;
    logic [4:0]         s_insert_position;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [4:0]         m_entry_count;
    logic signed [31:0] m_item_value;
    logic               m_item_valid;
    logic               m_last_item;

    list_mirror  mirror = new();
    int unsigned cycle_count = 0;
    int          rx_hold_cycles = 0;
    bit          idle_on = 1'b1;
    bit          growing = 1'b1;

    positional_list_engine_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_entry_value     (s_entry_value),
        .s_insert_position (s_insert_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_entry_count     (m_entry_count),
        .m_item_value      (m_item_value),
        .m_item_valid      (m_item_valid),
        .m_last_item       (m_last_item)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, mirror.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [2:0] req, input logic [31:0] v,
                                input logic [4:0] pos);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_req_type        = req;
        s_entry_value     = v;
        s_insert_position = pos;
        do @(posedge aclk); while (!s_ready);
        mirror.note_request(req, v, pos);
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_valid = 1'b0;
        while (mirror.pending() != 0) @(negedge aclk);
    endtask

    task automatic send_random_request();
        int          r;
        logic [2:0]  req;
        logic [4:0]  pos;
        r = $urandom_range(0, 99);
        if (mirror.held >= ple_pkg::LIMIT) growing = 1'b0;
        if (mirror.held == 0) growing = 1'b1;
        if ($urandom_range(0, 29) == 0) growing = !growing;
        if (r < 8) req = ple_pkg::REQ_DUMP;
        else if (r < 11) req = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
        else if (r < (growing ? 35 : 25)) req = ple_pkg::REQ_INS_FRONT;
        else if (r < (growing ? 55 : 35)) req = ple_pkg::REQ_INS_BACK;
        else if (r < (growing ? 85 : 50)) req = ple_pkg::REQ_INS_POS;
        else if ((r & 1) == 0) req = ple_pkg::REQ_DEL_FRONT;
        else req = ple_pkg::REQ_DEL_BACK;
        if ($urandom_range(0, 4) != 0) pos = 5'($urandom_range(1, mirror.held + 1));
        else pos = 5'($urandom_range(0, 31));
        send_request(req, pick_value(), pos);
    endtask

    initial begin
        list_result_t got;
        int           stall;
        m_ready = 1'b0;
        @(negedge aclk);
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.status = m_status;
            got.count  = m_entry_count;
            got.value  = m_item_value;
            got.valid  = m_item_valid;
            got.last   = m_last_item;
            mirror.check_result(got);
            @(negedge aclk);
        end
    end

    initial begin
        int i;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_req_type        = ple_pkg::REQ_INS_FRONT;
        s_entry_value     = '0;
        s_insert_position = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty list corner cases, then edge-value inserts, spare codes and dumps
        send_request(ple_pkg::REQ_DUMP, 32'h1234_5678, 5'd3);
        send_request(ple_pkg::REQ_DEL_FRONT, 32'd0, 5'd0);
        send_request(ple_pkg::REQ_DEL_BACK, 32'd0, 5'd0);
        send_request(ple_pkg::REQ_INS_POS, 32'd5, 5'd0);
        send_request(ple_pkg::REQ_INS_POS, 32'd5, 5'd2);
        send_request(ple_pkg::REQ_INS_POS, 32'h8000_0000, 5'd1);
        send_request(ple_pkg::REQ_INS_FRONT, 32'h7fff_ffff, 5'd31);
        send_request(ple_pkg::REQ_INS_BACK, 32'hffff_ffff, 5'd0);
        send_request(ple_pkg::REQ_INS_POS, 32'h0000_0001, 5'd31);
        send_request(ple_pkg::REQ_INS_POS, 32'h0000_0000, 5'd4);
        send_request(ple_pkg::REQ_INS_POS, $urandom, 5'd2);
        send_request(REQ_SPARE6, $urandom, 5'd31);
        send_request(REQ_SPARE7, $urandom, 5'd1);
        send_request(ple_pkg::REQ_DUMP, 32'd0, 5'd0);
        send_request(ple_pkg::REQ_DEL_FRONT, 32'd0, 5'd0);
        send_request(ple_pkg::REQ_DEL_BACK, 32'd0, 5'd0);
        send_request(ple_pkg::REQ_DUMP, 32'd0, 5'd0);

        // fill to capacity, then full and bad position checks and a full dump
        while (mirror.held < ple_pkg::LIMIT)
            send_request(ple_pkg::REQ_INS_BACK, $urandom, 5'($urandom));
        send_request(ple_pkg::REQ_INS_FRONT, 32'hdead_beef, 5'd0);
        send_request(ple_pkg::REQ_INS_POS, 32'hdead_beef, 5'(ple_pkg::LIMIT + 1));
        send_request(ple_pkg::REQ_INS_POS, 32'hdead_beef, 5'd0);
        send_request(ple_pkg::REQ_DUMP, 32'd0, 5'd0);
        wait_all_results();

        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            idle_on = !((i % 100) >= 60 && (i % 100) < 80);
            if (i == 160) rx_hold_cycles = 80;
            if (i == 240) wait_all_results();
            send_random_request();
        end
        s_valid = 1'b0;
        idle_on = 1'b1;

        wait_all_results();
        repeat (20) @(negedge aclk);
        if (mirror.pending() != 0) begin
            mirror.failures += mirror.pending();
            $display("%0d results never arrived", mirror.pending());
        end
        $display("covered %0d requests (%0d dumps) and checked %0d results", mirror.requests,
                 mirror.dumps, mirror.results_seen);
        $display("status hits: full %0d, bad position %0d, empty %0d, mismatches %0d",
                 mirror.hit_full, mirror.hit_badpos, mirror.hit_empty, mirror.failures);
        if (mirror.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
